// ----- rtl/core/pcu_pkg.sv -----
// shared types, codes and helper functions for the packed coefficient unpacker
`default_nettype none

package pcu_pkg;

  // width of every field-width quantity (declared width, bits needed)
  localparam int WidthBits = 6;
  localparam int CoefWidth = 63;
  localparam int HalfWidth = 62;
  localparam int CountWidth = 25;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_MODULUS     = 3'd0,
    CFG_HALF_BOUND  = 3'd1,
    CFG_SIGNED_MODE = 3'd2,
    CFG_FIELD_WIDTH = 3'd3,
    CFG_VALUE_COUNT = 3'd4
  } cfg_idx_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_PAD   = 2'd2,
    ST_WIDTH = 2'd3
  } status_t;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [CoefWidth-1:0]  modulus;
    logic [HalfWidth-1:0]  half_bound;
    logic                  signed_mode;
    logic [WidthBits-1:0]  field_width;
    logic [CountWidth-1:0] value_count;
  } pcu_cfg_t;

  // side information that travels with an extracted field
  typedef struct packed {
    logic last;
    logic pad;
  } pcu_fld_t;

  // width in use for each field
  function automatic logic [WidthBits-1:0] active_width(
    input logic                 signed_mode,
    input logic [WidthBits-1:0] field_width,
    input logic [WidthBits-1:0] coeff_bits
  );
    logic [WidthBits-1:0] w;
    w = coeff_bits;
    if (signed_mode) begin
      if (field_width == '0) begin
        w = WidthBits'(1);
      end else if (field_width > coeff_bits) begin
        w = coeff_bits;
      end else begin
        w = field_width;
      end
    end
    return w;
  endfunction

  // position of the highest set bit plus one, zero for zero
  function automatic logic [WidthBits-1:0] bit_len(input logic [CoefWidth-1:0] v);
    logic [WidthBits-1:0] n;
    n = '0;
    for (int i = 0; i < CoefWidth; i++) begin
      if (v[i]) begin
        n = WidthBits'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pcu_extract.sv -----
// byte holder and field extractor: cuts the bit stream into fields
`default_nettype none

module pcu_extract import pcu_pkg::*; #(
  parameter int COEFF_BITS = 63
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pcu_cfg_t              cfg,
  input  wire logic                  cfg_clear,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  fld_take,
  output logic                       fld_valid,
  output logic [COEFF_BITS-1:0]      fld_raw,
  output pcu_fld_t                   fld_info
);

  localparam int HeldBits = $clog2(COEFF_BITS);

  logic [7:0]            byte_r;
  logic                  byte_valid_r;
  logic [2:0]            pos_r;
  logic [COEFF_BITS-1:0] partial_r;
  logic [HeldBits-1:0]   held_r;
  logic [CountWidth-1:0] values_left_r;
  logic                  fld_valid_r;
  logic [COEFF_BITS-1:0] fld_raw_r;
  pcu_fld_t              fld_info_r;

  logic [WidthBits-1:0]  w;
  logic [WidthBits-1:0]  need;
  logic [3:0]            avail;
  logic                  fits;
  logic [CountWidth-1:0] vc_eff;
  logic [CountWidth-1:0] vl_eff;
  logic [7:0]            byte_sh;
  logic [7:0]            take_mask;
  logic [7:0]            bits_take;
  logic [COEFF_BITS-1:0] raw_nxt;
  logic                  last;
  logic [3:0]            pos_end;
  logic                  pad;
  logic                  byte_end;
  logic                  fld_free;
  logic                  step;
  logic                  emit;
  logic                  in_acc;

  // bits still needed for the current field and bits left in the byte
  always_comb begin
    w         = active_width(cfg.signed_mode, cfg.field_width, WidthBits'(COEFF_BITS));
    need      = w - WidthBits'(held_r);
    avail     = 4'd8 - {1'b0, pos_r};
    fits      = {2'b00, avail} >= need;
    vc_eff    = (cfg.value_count == '0) ? CountWidth'(1) : cfg.value_count;
    vl_eff    = (values_left_r == '0) ? vc_eff : values_left_r;
    byte_sh   = byte_r >> pos_r;
    take_mask = (need >= WidthBits'(8)) ? 8'hFF : ~(8'hFF << need[2:0]);
    bits_take = byte_sh & take_mask;
    raw_nxt   = partial_r | (COEFF_BITS'(bits_take) << held_r);
    last      = (vl_eff == CountWidth'(1));
    pos_end   = {1'b0, pos_r} + need[3:0];
    pad       = (byte_r >> pos_end) != 8'h00;
    byte_end  = !fits || last || (pos_end == 4'd8);
  end

  // handshake between byte holder, field register and input
  assign fld_free = !fld_valid_r || fld_take;
  assign step     = byte_valid_r && (!fits || fld_free);
  assign emit     = step && fits;
  assign in_stall = byte_valid_r && !(step && byte_end);
  assign in_acc   = in_valid && !in_stall;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r  <= 1'b0;
      pos_r         <= '0;
      partial_r     <= '0;
      held_r        <= '0;
      values_left_r <= '0;
      fld_valid_r   <= 1'b0;
    end else begin
      if (emit) begin
        fld_valid_r <= 1'b1;
      end else if (fld_take) begin
        fld_valid_r <= 1'b0;
      end

      if (cfg_clear) begin
        partial_r     <= '0;
        held_r        <= '0;
        values_left_r <= '0;
      end else if (step) begin
        if (fits) begin
          partial_r     <= '0;
          held_r        <= '0;
          values_left_r <= last ? '0 : vl_eff - CountWidth'(1);
        end else begin
          partial_r     <= raw_nxt;
          held_r        <= HeldBits'(WidthBits'(held_r) + WidthBits'(avail));
          values_left_r <= vl_eff;
        end
      end

      if (in_acc) begin
        byte_valid_r <= 1'b1;
        pos_r        <= '0;
      end else if (step && byte_end) begin
        byte_valid_r <= 1'b0;
      end else if (step) begin
        pos_r <= pos_end[2:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_data_byte;
    end
    if (emit) begin
      fld_raw_r       <= raw_nxt;
      fld_info_r.last <= last;
      fld_info_r.pad  <= last && pad;
    end
  end

  assign fld_valid = fld_valid_r;
  assign fld_raw   = fld_raw_r;
  assign fld_info  = fld_info_r;

  // a partly collected field never reaches the width in use
  a_held_below_width: assert property (@(posedge clk) disable iff (!rst_n)
    WidthBits'(held_r) < w)
    else $error("collected bit count reached the field width");

  // a byte is dropped only after it is fully used
  a_no_input_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    byte_valid_r && !step |-> in_stall)
    else $error("input taken while a byte is still held");

  // a padding flag only comes with the final value
  a_pad_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    fld_valid_r && fld_info_r.pad |-> fld_info_r.last)
    else $error("padding flag on a value that is not last");

endmodule

`default_nettype wire

// ----- rtl/core/pcu_check.sv -----
// range check, canonical mapping and width tracking for one extracted field
`default_nettype none

module pcu_check import pcu_pkg::*; #(
  parameter int COEFF_BITS = 63
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire pcu_cfg_t              cfg,
  input  wire logic                  cfg_clear,
  input  wire logic                  adv,
  input  wire logic [COEFF_BITS-1:0] fld_raw,
  input  wire pcu_fld_t              fld_info,
  output logic [CoefWidth-1:0]       coefficient,
  output logic [1:0]                 status
);

  logic [WidthBits-1:0] widest_r;

  logic [WidthBits-1:0] w;
  logic [CoefWidth-1:0] raw;
  logic [CoefWidth-1:0] mask;
  logic [CoefWidth-1:0] nr;
  logic [CoefWidth-1:0] half;
  logic                 neg;
  logic                 bad;
  logic [CoefWidth-1:0] coef;
  logic [WidthBits-1:0] need;
  logic [WidthBits-1:0] widest_new;
  status_t              st;

  // negative fields use nr = magnitude - 1 so that no second subtract is needed
  always_comb begin
    w    = active_width(cfg.signed_mode, cfg.field_width, WidthBits'(COEFF_BITS));
    raw  = CoefWidth'(fld_raw);
    mask = ~({CoefWidth{1'b1}} << w);
    nr   = ~raw & mask;
    half = CoefWidth'(cfg.half_bound);
    neg  = cfg.signed_mode && raw[w - WidthBits'(1)];
    need = '0;
    if (!cfg.signed_mode) begin
      bad  = raw >= cfg.modulus;
      coef = raw;
    end else if (!neg) begin
      bad  = (raw > half) || (raw >= cfg.modulus);
      coef = raw;
      need = bit_len(raw) + WidthBits'(1);
    end else begin
      bad  = (nr >= half) || (nr >= cfg.modulus);
      coef = cfg.modulus + ~nr;
      need = bit_len(nr) + WidthBits'(1);
    end
    widest_new = (cfg.signed_mode && need > widest_r) ? need : widest_r;
  end

  // status priority: range, then padding, then declared width
  always_comb begin
    priority if (bad) begin
      st = ST_RANGE;
    end else if (fld_info.last && fld_info.pad) begin
      st = ST_PAD;
    end else if (fld_info.last && cfg.signed_mode && widest_new != w) begin
      st = ST_WIDTH;
    end else begin
      st = ST_OK;
    end
  end

  assign coefficient = bad ? '0 : coef;
  assign status      = st;

  // widest minimal width over the vector
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear) begin
      widest_r <= WidthBits'(1);
    end else if (adv) begin
      widest_r <= fld_info.last ? WidthBits'(1) : widest_new;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/packed_coefficient_unpacker_unit.sv -----
// top level of the packed coefficient unpacker: config registers, datapath, result register
//
// Unpacks a vector of fixed-width fields packed LSB first into a byte stream.
// Input channel: in_valid / in_stall with in_data_byte, one word per byte.
// Result channel: out_valid / out_stall with out_coefficient, out_last_value
// and out_status; one word per completed field.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. A write to a known register also drops any vector in flight.
// Path: the byte that completes a field waits in the byte register, the field
// then moves to the field register and on to the result register.
// A byte is held until every field it completes has gone to the field register
// and, when bits are left over after its final field and the vector goes on,
// those bits are collected; the next byte can be taken as the held one ends.
// Reset (synchronous, rst_n low) restores the register defaults, empties all
// stages and starts a fresh vector. When out_stall is high and a result is shown,
// the result register holds, the field register fills behind it, and in_stall
// stays high while the held byte cannot be finished.
`default_nettype none

module packed_coefficient_unpacker_unit import pcu_pkg::*; #(
  parameter int COEFF_BITS = 63
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_data_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [CoefWidth-1:0]       out_coefficient,
  output logic                       out_last_value,
  output logic [1:0]                 out_status,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [CoefWidth-1:0]  cfg_data
);

  pcu_cfg_t              cfg_r;
  logic                  out_valid_r;
  logic [CoefWidth-1:0]  out_coefficient_r;
  logic                  out_last_value_r;
  logic [1:0]            out_status_r;

  logic                  cfg_we;
  logic                  cfg_clear;
  logic                  out_en;
  logic                  adv;
  logic                  fld_valid;
  logic [COEFF_BITS-1:0] fld_raw;
  pcu_fld_t              fld_info;
  logic [CoefWidth-1:0]  chk_coefficient;
  logic [1:0]            chk_status;

  // configuration writes
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_clear = cfg_we && (cfg_index <= CFG_VALUE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.modulus     <= CoefWidth'(3);
      cfg_r.half_bound  <= HalfWidth'(1);
      cfg_r.signed_mode <= 1'b0;
      cfg_r.field_width <= WidthBits'(1);
      cfg_r.value_count <= CountWidth'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODULUS:     cfg_r.modulus     <= cfg_data;
        CFG_HALF_BOUND:  cfg_r.half_bound  <= cfg_data[HalfWidth-1:0];
        CFG_SIGNED_MODE: cfg_r.signed_mode <= cfg_data[0];
        CFG_FIELD_WIDTH: cfg_r.field_width <= cfg_data[WidthBits-1:0];
        CFG_VALUE_COUNT: cfg_r.value_count <= cfg_data[CountWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  // result register advance
  assign out_en = !out_valid_r || !out_stall;
  assign adv    = fld_valid && out_en;

  pcu_extract #(
    .COEFF_BITS (COEFF_BITS)
  ) u_extract (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .cfg_clear    (cfg_clear),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .fld_take     (adv),
    .fld_valid    (fld_valid),
    .fld_raw      (fld_raw),
    .fld_info     (fld_info)
  );

  pcu_check #(
    .COEFF_BITS (COEFF_BITS)
  ) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .cfg_clear   (cfg_clear),
    .adv         (adv),
    .fld_raw     (fld_raw),
    .fld_info    (fld_info),
    .coefficient (chk_coefficient),
    .status      (chk_status)
  );

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_coefficient_r <= chk_coefficient;
      out_last_value_r  <= fld_info.last;
      out_status_r      <= chk_status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_coefficient = out_coefficient_r;
  assign out_last_value  = out_last_value_r;
  assign out_status      = out_status_r;

  // an out of range value carries a zero coefficient
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_RANGE) |-> (out_coefficient_r == '0))
    else $error("out of range result with nonzero coefficient");

  // padding and width codes only close a vector
  a_tail_codes_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ((out_status_r == ST_PAD) || (out_status_r == ST_WIDTH))
      |-> out_last_value_r)
    else $error("tail status on a value that is not last");

  // nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
